// ===== design/sis_pkg.sv =====
package sis_pkg;

    localparam int PORT_BITS         = 32;
    localparam int MAX_INTERVALS_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;

    // Request opcodes.
    localparam logic OP_CLEAR    = 1'b0;
    localparam logic OP_SUBTRACT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new request and classify it
        logic rd_issue;   // read the list entry at the read pointer
        logic eval;       // rewrite the entry that was read into the other bank
        logic wr_upper;   // write the upper half of a split entry
        logic commit;     // make the rewritten bank the live list
        logic out_load;   // place the entry that was read in the output register
        logic out_empty;  // place the empty-list marker in the output register
    } sis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic do_sub;     // the request needs a walk over the list
        logic rd_done;    // every live entry has been read
        logic split_up;   // the entry being evaluated leaves an upper half to write
        logic list_empty; // the live list has no entries
        logic out_taken;  // the output register is handed over this cycle
        logic out_last;   // the output register holds the final result
    } sis_status_t;

endpackage

// ===== design/sis_ctrl.sv =====
module sis_ctrl
    import sis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sis_status_t status,
    output sis_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHK   = 3'd1;
    localparam logic [2:0] ST_PRD   = 3'd2;
    localparam logic [2:0] ST_PEV   = 3'd3;
    localparam logic [2:0] ST_PWR2  = 3'd4;
    localparam logic [2:0] ST_DRD   = 3'd5;
    localparam logic [2:0] ST_DLD   = 3'd6;
    localparam logic [2:0] ST_DHOLD = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                state_next = status.do_sub ? ST_PRD : ST_DRD;
            end
            ST_PRD: begin
                if (status.rd_done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_DRD;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_PEV;
                end
            end
            ST_PEV: begin
                cmd.eval   = 1'b1;
                state_next = status.split_up ? ST_PWR2 : ST_PRD;
            end
            ST_PWR2: begin
                cmd.wr_upper = 1'b1;
                state_next   = ST_PRD;
            end
            ST_DRD: begin
                if (status.list_empty) begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_DHOLD;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_DLD;
                end
            end
            ST_DLD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_DHOLD;
            end
            ST_DHOLD: begin
                if (status.out_taken) begin
                    if (status.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next entry as soon as the current result leaves.
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_DLD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== design/sis_datapath.sv =====
module sis_datapath
    import sis_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sis_cmd_t             cmd,
    output sis_status_t          status,
    input  logic                 s_opcode,
    input  logic [PORT_BITS-1:0] s_t_min,
    input  logic [PORT_BITS-1:0] s_t_max,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PORT_BITS-1:0] m_interval_start,
    output logic [PORT_BITS-1:0] m_interval_end,
    output logic                 m_last,
    output logic                 m_list_empty,
    output logic                 m_bad_request,
    output logic                 m_overflow
);

    localparam int IDX_W  = $clog2(MAX_INTERVALS);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef logic [TIME_BITS-1:0] time_t;

    localparam time_t TIME_INF = '1;

    // Two banks: the live list is read from one while the updated list is
    // written to the other.
    logic [2*TIME_BITS-1:0] list_mem [DEPTH];
    logic [2*TIME_BITS-1:0] rd_word_reg;

    logic             bank_reg,   bank_next;
    logic             init_reg,   init_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic             do_sub_reg, do_sub_next;
    logic             bad_reg,    bad_next;
    logic             ovf_reg,    ovf_next;
    logic             valid_reg,  valid_next;
    logic             last_reg,   last_next;
    logic             empty_reg,  empty_next;
    time_t            lo_reg,     lo_next;
    time_t            hi_reg,     hi_next;
    time_t            up_s_reg,   up_s_next;
    time_t            up_e_reg,   up_e_next;
    time_t            out_s_reg,  out_s_next;
    time_t            out_e_reg,  out_e_next;

    time_t in_lo, in_hi, cur_s, cur_e, w_s, w_e;
    logic  pass, covered, split, room, wr_en;
    logic  [ADDR_W-1:0] rd_addr, wr_addr;

    assign in_lo = time_t'(s_t_min);
    assign in_hi = time_t'(s_t_max);

    // After reset or a clear the list is the single interval from zero to
    // infinity, which is supplied here rather than held in the memory.
    assign cur_s = init_reg ? '0       : rd_word_reg[2*TIME_BITS-1:TIME_BITS];
    assign cur_e = init_reg ? TIME_INF : rd_word_reg[TIME_BITS-1:0];

    always_comb begin
        pass    = (lo_reg >= cur_e) || (hi_reg <= cur_s);
        covered = !pass && (lo_reg <= cur_s) && (hi_reg >= cur_e);
        split   = !pass && (lo_reg > cur_s) && (hi_reg < cur_e);
        room    = (count_reg < CNT_MAX);
        w_s     = cur_s;
        w_e     = cur_e;
        if (!pass) begin
            if (lo_reg <= cur_s) begin
                w_s = hi_reg;
            end else begin
                w_e = lo_reg;
            end
        end
        if (cmd.wr_upper) begin
            w_s = up_s_reg;
            w_e = up_e_reg;
        end
        wr_en = (cmd.eval && !covered) || cmd.wr_upper;
    end

    assign rd_addr = {bank_reg, rd_idx_reg[IDX_W-1:0]};
    assign wr_addr = {~bank_reg, wr_cnt_reg[IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            list_mem[wr_addr] <= {w_s, w_e};
        end
        if (cmd.rd_issue) begin
            rd_word_reg <= list_mem[rd_addr];
        end
    end

    always_comb begin
        bank_next   = bank_reg;
        init_next   = init_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_cnt_next = wr_cnt_reg;
        do_sub_next = do_sub_reg;
        bad_next    = bad_reg;
        ovf_next    = ovf_reg;
        valid_next  = valid_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        up_s_next   = up_s_reg;
        up_e_next   = up_e_reg;
        out_s_next  = out_s_reg;
        out_e_next  = out_e_reg;

        if (cmd.load) begin
            lo_next     = in_lo;
            hi_next     = in_hi;
            rd_idx_next = '0;
            wr_cnt_next = '0;
            ovf_next    = 1'b0;
            bad_next    = (s_opcode == OP_SUBTRACT) && (in_lo >= in_hi);
            do_sub_next = (s_opcode == OP_SUBTRACT) && (in_lo < in_hi) && (count_reg != '0);
            if (s_opcode == OP_CLEAR) begin
                init_next  = 1'b1;
                count_next = CNT_ONE;
            end
        end
        if (cmd.rd_issue) begin
            rd_idx_next = rd_idx_reg + CNT_ONE;
        end
        if (wr_en) begin
            wr_cnt_next = wr_cnt_reg + CNT_ONE;
        end
        if (cmd.eval && split) begin
            up_s_next = hi_reg;
            up_e_next = cur_e;
            if (!room) begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.commit) begin
            bank_next   = ~bank_reg;
            count_next  = wr_cnt_reg;
            init_next   = 1'b0;
            rd_idx_next = '0;
        end
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
            out_s_next = cur_s;
            out_e_next = cur_e;
            last_next  = (rd_idx_reg == count_reg);
            empty_next = 1'b0;
        end
        if (cmd.out_empty) begin
            valid_next = 1'b1;
            out_s_next = '0;
            out_e_next = '0;
            last_next  = 1'b1;
            empty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg   <= 1'b0;
            init_reg   <= 1'b1;
            count_reg  <= CNT_ONE;
            rd_idx_reg <= '0;
            wr_cnt_reg <= '0;
            do_sub_reg <= 1'b0;
            bad_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            bank_reg   <= bank_next;
            init_reg   <= init_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            wr_cnt_reg <= wr_cnt_next;
            do_sub_reg <= do_sub_next;
            bad_reg    <= bad_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        empty_reg <= empty_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        up_s_reg  <= up_s_next;
        up_e_reg  <= up_e_next;
        out_s_reg <= out_s_next;
        out_e_reg <= out_e_next;
    end

    assign status.do_sub     = do_sub_reg;
    assign status.rd_done    = (rd_idx_reg == count_reg);
    assign status.split_up   = split && room;
    assign status.list_empty = (count_reg == '0);
    assign status.out_taken  = valid_reg && m_ready;
    assign status.out_last   = last_reg;

    assign m_valid          = valid_reg;
    assign m_interval_start = PORT_BITS'(out_s_reg);
    assign m_interval_end   = PORT_BITS'(out_e_reg);
    assign m_last           = last_reg;
    assign m_list_empty     = empty_reg;
    assign m_bad_request    = bad_reg;
    assign m_overflow       = ovf_reg;

endmodule

// ===== design/safe_interval_subtract_core.sv =====
// Flow: a subtract walks the n live entries, rewriting each into the other bank (plus the upper
// part of a split that has room for it), and then the list is dumped; clear and rejected
// requests skip the walk.
// Throughput: one request at a time; the single read port of the interval memory serves both
// the walk and the list dump.
// Reset (synchronous, active low) leaves the list as the single interval [0, infinity).
module safe_interval_subtract_core
    import sis_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [PORT_BITS-1:0] s_t_min,
    input  logic [PORT_BITS-1:0] s_t_max,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PORT_BITS-1:0] m_interval_start,
    output logic [PORT_BITS-1:0] m_interval_end,
    output logic                 m_last,
    output logic                 m_list_empty,
    output logic                 m_bad_request,
    output logic                 m_overflow
);

    sis_cmd_t    cmd;
    sis_status_t status;

    sis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sis_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .TIME_BITS     (TIME_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_opcode         (s_opcode),
        .s_t_min          (s_t_min),
        .s_t_max          (s_t_max),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_start (m_interval_start),
        .m_interval_end   (m_interval_end),
        .m_last           (m_last),
        .m_list_empty     (m_list_empty),
        .m_bad_request    (m_bad_request),
        .m_overflow       (m_overflow)
    );

endmodule

// ===== design/sis_checker.sv =====
module sis_checker
    import sis_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [PORT_BITS-1:0] m_interval_start,
    input logic [PORT_BITS-1:0] m_interval_end,
    input logic                 m_last,
    input logic                 m_list_empty,
    input logic                 m_bad_request,
    input logic                 m_overflow
);

    // A result that is held back keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_interval_start)
            && $stable(m_interval_end) && $stable(m_last) && $stable(m_list_empty)
            && $stable(m_bad_request) && $stable(m_overflow))
        else $error("result changed while stalled");

    // A new request is only taken once the previous dump has finished.
    a_idle_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("result pending while accepting a request");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted during processing");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready)
        else $error("block not ready after the final result");

    // The empty marker is always the only result, with zero interval fields.
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_empty |-> m_last && (m_interval_start == '0)
            && (m_interval_end == '0))
        else $error("malformed empty-list result");

endmodule

bind safe_interval_subtract_core sis_checker u_sis_checker (.*);

// ===== bench/safe_interval_subtract_core_tb.sv =====
module safe_interval_subtract_core_tb;
    import sis_pkg::*;

    localparam int SLOTS       = MAX_INTERVALS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 300;

    typedef logic [PORT_BITS-1:0] stamp_t;

    localparam stamp_t T_INF = '1;

    typedef struct {
        stamp_t start_t;
        stamp_t end_t;
        logic   last;
        logic   empty;
        logic   bad;
        logic   ovf;
    } interval_beat_t;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    logic   s_opcode;
    stamp_t s_t_min;
    stamp_t s_t_max;
    logic   m_valid;
    logic   m_ready;
    stamp_t m_interval_start;
    stamp_t m_interval_end;
    logic   m_last;
    logic   m_list_empty;
    logic   m_bad_request;
    logic   m_overflow;

    // Predicted contents of the safe list.
    stamp_t safe_lo [SLOTS];
    stamp_t safe_hi [SLOTS];
    int     safe_count;

    interval_beat_t expected_intervals[$];

    int src_idle_pct;
    int dst_idle_pct;
    logic drain_hold;
    int error_count;
    int cycle_count;

    safe_interval_subtract_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_t_min          (s_t_min),
        .s_t_max          (s_t_max),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_start (m_interval_start),
        .m_interval_end   (m_interval_end),
        .m_last           (m_last),
        .m_list_empty     (m_list_empty),
        .m_bad_request    (m_bad_request),
        .m_overflow       (m_overflow)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void reset_safe_list();
        safe_lo[0] = '0;
        safe_hi[0] = T_INF;
        safe_count = 1;
    endfunction

    // Updates the predicted list for one request and queues the dump it causes.
    function automatic void apply_request(logic op, stamp_t lo, stamp_t hi);
        interval_beat_t beat;
        logic bad_flag;
        logic ovf_flag;
        int i;
        stamp_t s;
        stamp_t e;
        bad_flag = 1'b0;
        ovf_flag = 1'b0;
        if (op == OP_CLEAR) begin
            reset_safe_list();
        end else if (lo >= hi) begin
            bad_flag = 1'b1;
        end else begin
            i = 0;
            while (i < safe_count) begin
                s = safe_lo[i];
                e = safe_hi[i];
                if (lo >= e) begin
                    i++;
                end else if (hi <= s) begin
                    break;
                end else if (lo <= s && hi >= e) begin
                    for (int k = i; k + 1 < safe_count; k++) begin
                        safe_lo[k] = safe_lo[k + 1];
                        safe_hi[k] = safe_hi[k + 1];
                    end
                    safe_count--;
                end else if (lo <= s) begin
                    safe_lo[i] = hi;
                    i++;
                end else if (hi >= e) begin
                    safe_hi[i] = lo;
                    i++;
                end else begin
                    // The collision sits strictly inside: split, or drop the upper part.
                    if (safe_count < SLOTS) begin
                        for (int k = safe_count; k > i + 1; k--) begin
                            safe_lo[k] = safe_lo[k - 1];
                            safe_hi[k] = safe_hi[k - 1];
                        end
                        safe_lo[i + 1] = hi;
                        safe_hi[i + 1] = e;
                        safe_count++;
                    end else begin
                        ovf_flag = 1'b1;
                    end
                    safe_hi[i] = lo;
                    i++;
                end
            end
        end
        beat.bad = bad_flag;
        beat.ovf = ovf_flag;
        if (safe_count == 0) begin
            beat.start_t = '0;
            beat.end_t   = '0;
            beat.last    = 1'b1;
            beat.empty   = 1'b1;
            expected_intervals.push_back(beat);
        end else begin
            for (int k = 0; k < safe_count; k++) begin
                beat.start_t = safe_lo[k];
                beat.end_t   = safe_hi[k];
                beat.last    = (k + 1 == safe_count);
                beat.empty   = 1'b0;
                expected_intervals.push_back(beat);
            end
        end
    endfunction

    // Offers one request after a random gap and returns at the edge that accepts it.
    task automatic offer_request(input logic op, input stamp_t lo, input stamp_t hi);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_t_min  <= lo;
        s_t_max  <= hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(op, lo, hi);
    endtask

    task automatic report_mismatch(input string what, input stamp_t got, input stamp_t want);
        $display("mismatch at cycle %0d: %s got %h expected %h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic test_directed();
        // Split, clip at the low end, clip at the high end.
        offer_request(OP_SUBTRACT, 32'h0001_0000, 32'h0002_0000);
        offer_request(OP_SUBTRACT, 32'h0000_0000, 32'h0000_8000);
        offer_request(OP_SUBTRACT, 32'h0001_8000, 32'h0003_0000);
        offer_request(OP_SUBTRACT, 32'h0000_F000, 32'h0001_8000);
        // Empty and inverted requests leave the list alone.
        offer_request(OP_SUBTRACT, 32'h1234_5678, 32'h1234_5678);
        offer_request(OP_SUBTRACT, T_INF, T_INF);
        offer_request(OP_SUBTRACT, T_INF, 32'h0000_0000);
        // Wipe everything, then subtract from the empty list.
        offer_request(OP_SUBTRACT, 32'h0000_0000, T_INF);
        offer_request(OP_SUBTRACT, 32'h0000_0005, 32'h0000_000A);
        offer_request(OP_CLEAR, T_INF, 32'h0000_0000);
        // Sixteen splits of the tail: the last one finds the list full.
        for (int k = 1; k <= SLOTS; k++)
            offer_request(OP_SUBTRACT, stamp_t'(k) << 20, (stamp_t'(k) << 20) + 32'h100);
        offer_request(OP_SUBTRACT, 32'h0080_0000, T_INF);
        offer_request(OP_CLEAR, 32'h0000_0000, T_INF);
    endtask

    task automatic test_random(input int count);
        int pick;
        int span;
        int j;
        stamp_t lo;
        stamp_t hi;
        stamp_t a;
        stamp_t b;
        logic [PORT_BITS:0] sum;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            a = $urandom;
            b = $urandom;
            lo = a;
            span = (pick < 30) ? $urandom_range(1, 1 << 28) : $urandom_range(1, 1 << 16);
            if (pick >= 80 && safe_count > 0) begin
                // Land exactly on an existing boundary.
                j = $urandom_range(0, safe_count - 1);
                lo = $urandom_range(0, 1) ? safe_lo[j] : safe_hi[j] - stamp_t'(span);
            end
            sum = lo + span;
            hi = sum[PORT_BITS] ? T_INF : sum[PORT_BITS-1:0];
            if (pick >= 80 && safe_count > 0 && $urandom_range(0, 2) == 0)
                hi = safe_hi[j];
            if (pick < 4) begin
                offer_request(OP_CLEAR, a, b);
            end else if (pick < 6) begin
                offer_request(OP_SUBTRACT, '0, T_INF);
            end else if (pick < 12) begin
                if ($urandom_range(0, 3) == 0)
                    offer_request(OP_SUBTRACT, T_INF, b);
                else
                    offer_request(OP_SUBTRACT, (a > b) ? a : b, (a > b) ? b : a);
            end else if (pick < 18) begin
                offer_request(OP_SUBTRACT, (a < b) ? a : b, (a < b) ? b : a);
            end else if (pick < 22) begin
                offer_request(OP_SUBTRACT, lo, T_INF);
            end else begin
                offer_request(OP_SUBTRACT, lo, hi);
            end
        end
    endtask

    // Holds the result side off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        offer_request(OP_CLEAR, '0, '0);
        fork
            begin
                drain_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                drain_hold <= 1'b0;
            end
            for (int n = 0; n < 12; n++)
                offer_request(OP_SUBTRACT, stamp_t'(n) << 24, (stamp_t'(n) << 24) + 32'h80_0000);
        join
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (drain_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin : check_dump
        interval_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_intervals.size() == 0) begin
                report_mismatch("unexpected interval start", m_interval_start, '0);
            end else begin
                want = expected_intervals.pop_front();
                if (m_interval_start !== want.start_t)
                    report_mismatch("interval_start", m_interval_start, want.start_t);
                if (m_interval_end !== want.end_t)
                    report_mismatch("interval_end", m_interval_end, want.end_t);
                if (m_last !== want.last)
                    report_mismatch("last", stamp_t'(m_last), stamp_t'(want.last));
                if (m_list_empty !== want.empty)
                    report_mismatch("list_empty", stamp_t'(m_list_empty), stamp_t'(want.empty));
                if (m_bad_request !== want.bad)
                    report_mismatch("bad_request", stamp_t'(m_bad_request), stamp_t'(want.bad));
                if (m_overflow !== want.ovf)
                    report_mismatch("overflow", stamp_t'(m_overflow), stamp_t'(want.ovf));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("safe_interval_subtract_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = OP_CLEAR;
        s_t_min      = '0;
        s_t_max      = '0;
        drain_hold   = 1'b0;
        src_idle_pct = 17;
        dst_idle_pct = 87;
        reset_safe_list();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(115);
        src_idle_pct = 87;
        dst_idle_pct = 17;
        test_random(115);
        test_backpressure();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random(115);

        s_valid <= 1'b0;
        while (expected_intervals.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("safe_interval_subtract_core_tb: done, clean");
        else
            $display("safe_interval_subtract_core_tb: done, errors");
        $finish;
    end

endmodule
